/* hw/rtl/soc_pkg.sv */
`timescale 1ns / 1ps

package soc_pkg;

  localparam int PATTERN_MAX_DEF = 8;
  localparam int CHAR_BITS_DEF   = 16;

  localparam int COUNT_W  = 16;
  localparam int CFG_W    = 64;
  localparam int LEN_W    = 4;
  localparam int PCHAR_W  = 16;
  localparam int PCHAR_PER_WORD = CFG_W / PCHAR_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // ascii lower-case range and the distance to upper case
  localparam int ASCII_LOWER_A = 'h61;
  localparam int ASCII_LOWER_Z = 'h7A;
  localparam int ASCII_CASE_OFS = 'h20;

  typedef enum logic [1:0] {
    CFG_PATTERN_LEN        = 2'd0,
    CFG_PATTERN_CHARS_LOW  = 2'd1,
    CFG_PATTERN_CHARS_HIGH = 2'd2,
    CFG_CASE_SENSITIVE     = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [LEN_W-1:0] pattern_len;
    logic             case_sensitive;
  } cfg_ctrl_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               matched_here;
    logic               string_done;
  } result_t;

endpackage

/* hw/rtl/soc_cfg_regs.sv */
`timescale 1ns / 1ps

module soc_cfg_regs #(
  parameter int PATTERN_MAX = soc_pkg::PATTERN_MAX_DEF,
  parameter int CHAR_BITS   = soc_pkg::CHAR_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  soc_pkg::cfg_index_t      cfg_index,
  input  logic [soc_pkg::CFG_W-1:0] cfg_data,
  output soc_pkg::cfg_ctrl_t       ctrl,
  output logic [CHAR_BITS-1:0]     pat [PATTERN_MAX]
);

  logic [soc_pkg::LEN_W-1:0] len_r;
  logic [soc_pkg::CFG_W-1:0] chars_low_r;
  logic [soc_pkg::CFG_W-1:0] chars_high_r;
  logic                      case_sens_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r        <= '0;
      chars_low_r  <= '0;
      chars_high_r <= '0;
      case_sens_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        soc_pkg::CFG_PATTERN_LEN:        len_r        <= cfg_data[soc_pkg::LEN_W-1:0];
        soc_pkg::CFG_PATTERN_CHARS_LOW:  chars_low_r  <= cfg_data;
        soc_pkg::CFG_PATTERN_CHARS_HIGH: chars_high_r <= cfg_data;
        soc_pkg::CFG_CASE_SENSITIVE:     case_sens_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign ctrl.pattern_len    = len_r;
  assign ctrl.case_sensitive = case_sens_r;

  // only eight characters are stored, the rest read as zero
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_pat
    logic [soc_pkg::PCHAR_W-1:0] raw;
    if (k < soc_pkg::PCHAR_PER_WORD) begin : g_low
      assign raw = chars_low_r[soc_pkg::PCHAR_W*k +: soc_pkg::PCHAR_W];
    end else if (k < 2*soc_pkg::PCHAR_PER_WORD) begin : g_high
      assign raw = chars_high_r[soc_pkg::PCHAR_W*(k-soc_pkg::PCHAR_PER_WORD) +:
                                soc_pkg::PCHAR_W];
    end else begin : g_zero
      assign raw = '0;
    end
    assign pat[k] = CHAR_BITS'(raw);
  end

endmodule

/* hw/rtl/soc_matcher.sv */
`timescale 1ns / 1ps

module soc_matcher #(
  parameter int PATTERN_MAX = soc_pkg::PATTERN_MAX_DEF,
  parameter int CHAR_BITS   = soc_pkg::CHAR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic [CHAR_BITS-1:0] in_ch,
  input  logic                 in_last,
  input  soc_pkg::cfg_ctrl_t   ctrl,
  input  logic [CHAR_BITS-1:0] pat [PATTERN_MAX],
  output soc_pkg::result_t     res
);

  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int BW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int CMPW = (LW > soc_pkg::LEN_W) ? LW : soc_pkg::LEN_W;
  localparam logic [LW-1:0] FILL_MAX = LW'(PATTERN_MAX);

  logic [CHAR_BITS-1:0]        win_r [PATTERN_MAX];
  logic [CHAR_BITS-1:0]        win_nxt [PATTERN_MAX];
  logic [LW-1:0]               fill_r, fill_nxt, fill_adv;
  logic [BW-1:0]               blocked_r, blocked_nxt, blocked_adv;
  logic [soc_pkg::COUNT_W-1:0] count_r, count_nxt, count_adv;
  logic [LW-1:0]               len;
  logic                        match_len [PATTERN_MAX+1];
  logic                        hit;

  function automatic logic [CHAR_BITS-1:0] fold(input logic [CHAR_BITS-1:0] c,
                                                 input logic exact);
    logic [CHAR_BITS-1:0] r;
    r = c;
    if (!exact && c >= CHAR_BITS'(soc_pkg::ASCII_LOWER_A) &&
        c <= CHAR_BITS'(soc_pkg::ASCII_LOWER_Z))
      r = c - CHAR_BITS'(soc_pkg::ASCII_CASE_OFS);
    return r;
  endfunction

  // clamp an oversized length
  always_comb begin
    if (CMPW'(ctrl.pattern_len) > CMPW'(PATTERN_MAX))
      len = FILL_MAX;
    else
      len = LW'(ctrl.pattern_len);
  end

  // shifted window including the arriving character
  always_comb begin
    win_nxt[0] = in_ch;
    for (int i = 1; i < PATTERN_MAX; i++)
      win_nxt[i] = win_r[i-1];
  end

  // one compare row for every possible pattern length, then pick by len
  always_comb begin
    match_len[0] = 1'b0;
    for (int l = 1; l <= PATTERN_MAX; l++) begin
      match_len[l] = 1'b1;
      for (int k = 0; k < PATTERN_MAX; k++) begin
        if (k < l) begin
          if (fold(win_nxt[l-1-k], ctrl.case_sensitive) !=
              fold(pat[k], ctrl.case_sensitive))
            match_len[l] = 1'b0;
        end
      end
    end
  end

  assign fill_adv = (fill_r < FILL_MAX) ? fill_r + 1'b1 : fill_r;
  assign hit = (blocked_r == '0) && (len != '0) && (fill_adv >= len) && match_len[len];

  always_comb begin
    if (hit)
      blocked_adv = BW'(len - 1'b1);
    else if (blocked_r != '0)
      blocked_adv = blocked_r - 1'b1;
    else
      blocked_adv = blocked_r;
  end

  assign count_adv = (hit && count_r != soc_pkg::COUNT_MAX) ? count_r + 1'b1 : count_r;

  // end of string clears everything for the next one
  always_comb begin
    fill_nxt    = in_last ? '0 : fill_adv;
    blocked_nxt = in_last ? '0 : blocked_adv;
    count_nxt   = in_last ? '0 : count_adv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      blocked_r <= '0;
      count_r   <= '0;
      for (int i = 0; i < PATTERN_MAX; i++)
        win_r[i] <= '0;
    end else if (in_fire) begin
      fill_r    <= fill_nxt;
      blocked_r <= blocked_nxt;
      count_r   <= count_nxt;
      for (int i = 0; i < PATTERN_MAX; i++)
        win_r[i] <= in_last ? '0 : win_nxt[i];
    end
  end

  assign res.count        = count_adv;
  assign res.matched_here = hit;
  assign res.string_done  = in_last;

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_last |=> fill_r == '0 && blocked_r == '0 && count_r == '0)
    else $error("string state not cleared after last character");

  a_blocked_bound: assert property (@(posedge clk) disable iff (!rst_n)
    BW'(blocked_r) < BW'(PATTERN_MAX) || PATTERN_MAX == (1 << BW))
    else $error("blocked count beyond pattern span");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_last && hit && count_r != soc_pkg::COUNT_MAX
    |=> count_r == $past(count_r) + 1'b1)
    else $error("counted match did not advance the count");

  a_no_hit_while_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_last && hit && len > 1 |=> blocked_r != '0)
    else $error("match did not block the overlapped characters");

endmodule

/* hw/rtl/soc_out_buf.sv */
`timescale 1ns / 1ps

module soc_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  soc_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output soc_pkg::result_t out_data
);

  soc_pkg::result_t mem [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = cnt_r != 2'd0;
  assign full      = cnt_r == 2'd2;
  assign out_data  = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop)
      cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push)
      cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push)
      mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push)
        wr_ptr_r <= ~wr_ptr_r;
      if (pop)
        rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output buffer overflow");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r))
    else $error("output buffer pointers out of step");

  a_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("transfer into a full output buffer");

endmodule

/* hw/rtl/substring_occurrence_counter.sv */
`timescale 1ns / 1ps

// Counts non-overlapping, leftmost-first occurrences of a pattern of up to
// PATTERN_MAX characters in a stream of characters.
// Input channel: one character per transfer (in_ch) with in_last_char on the
// final character of each string. Result channel: one result per character,
// giving the running count, whether a counted match ends there, and whether
// the string ended (count is then final, and string state clears).
// Configuration: cfg_we with cfg_index / cfg_data, written while idle;
// new values apply to the next character.
// Each character's result is registered in a two-entry result buffer and
// offered from there. Throughput: one character per cycle while in_stall is
// low; the window compares for all pattern lengths form one parallel equality stage.
// When the receiver stalls, the buffer takes one more result and then in_stall
// rises until a result drains; nothing is dropped.
// Reset (rst_n low, synchronous): pattern length 0, pattern characters 0,
// case-sensitive compare, string state and result buffer empty.
module substring_occurrence_counter #(
  parameter int PATTERN_MAX = soc_pkg::PATTERN_MAX_DEF,
  parameter int CHAR_BITS   = soc_pkg::CHAR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [CHAR_BITS-1:0]        in_ch,
  input  logic                        in_last_char,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [soc_pkg::COUNT_W-1:0] out_count,
  output logic                        out_matched_here,
  output logic                        out_string_done,
  input  logic                        cfg_we,
  input  soc_pkg::cfg_index_t         cfg_index,
  input  logic [soc_pkg::CFG_W-1:0]   cfg_data
);

  soc_pkg::cfg_ctrl_t   ctrl;
  logic [CHAR_BITS-1:0] pat [PATTERN_MAX];
  soc_pkg::result_t     res, out_res;
  logic                 fire, full;

  assign in_stall = full;
  assign fire     = in_valid && !in_stall;

  soc_cfg_regs #(
    .PATTERN_MAX(PATTERN_MAX),
    .CHAR_BITS  (CHAR_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .ctrl     (ctrl),
    .pat      (pat)
  );

  soc_matcher #(
    .PATTERN_MAX(PATTERN_MAX),
    .CHAR_BITS  (CHAR_BITS)
  ) u_match (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_fire(fire),
    .in_ch  (in_ch),
    .in_last(in_last_char),
    .ctrl   (ctrl),
    .pat    (pat),
    .res    (res)
  );

  soc_out_buf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fire),
    .push_data(res),
    .full     (full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_res)
  );

  assign out_count        = out_res.count;
  assign out_matched_here = out_res.matched_here;
  assign out_string_done  = out_res.string_done;

endmodule
